>>> rtl/core/vwip_pkg.sv
package vwip_pkg;

  localparam int WORD_BITS = 64;
  localparam int ID_BITS   = 32;
  localparam int CFG_BITS  = 6;
  localparam int CNT_BITS  = $clog2(WORD_BITS);

  localparam logic [CFG_BITS-1:0] BPI_RESET = CFG_BITS'(ID_BITS);
  localparam logic [CFG_BITS-1:0] BPI_MIN   = CFG_BITS'(1);

  // Word being filled and its number of valid bits
  typedef struct packed {
    logic [WORD_BITS-1:0] pending;
    logic [CNT_BITS-1:0]  fill;
  } pack_state_t;

  // Per-step control out of the packing datapath
  typedef struct packed {
    logic emit;
    logic word_last;
    logic done;
  } pack_ctl_t;

  // Clamp the configured width into 1..ID_BITS
  function automatic logic [CFG_BITS-1:0] eff_width(input logic [CFG_BITS-1:0] bpi);
    logic [CFG_BITS-1:0] w;
    w = bpi;
    if (w == '0) begin
      w = BPI_MIN;
    end else if (w > CFG_BITS'(ID_BITS)) begin
      w = CFG_BITS'(ID_BITS);
    end
    return w;
  endfunction

endpackage

>>> rtl/core/vwip_pack.sv
module vwip_pack (
  input  vwip_pkg::pack_state_t               state_cur,
  input  logic [vwip_pkg::ID_BITS-1:0]        id_raw,
  input  logic                                id_last,
  input  logic                                flush_phase,
  input  logic [vwip_pkg::CFG_BITS-1:0]       width,
  output vwip_pkg::pack_state_t               state_nxt,
  output logic [vwip_pkg::WORD_BITS-1:0]      word,
  output vwip_pkg::pack_ctl_t                 ctl
);
  import vwip_pkg::*;

  logic [ID_BITS-1:0]   id_mask;
  logic [ID_BITS-1:0]   id_val;
  logic [WORD_BITS-1:0] merged;
  logic [CNT_BITS:0]    total;
  logic [CNT_BITS-1:0]  rem;
  logic [CFG_BITS-1:0]  carry_shift;
  logic [ID_BITS-1:0]   carry_bits;

  // Mask the id to the width, append it above the pending bits
  assign id_mask     = {ID_BITS{1'b1}} >> (CFG_BITS'(ID_BITS) - width);
  assign id_val      = id_raw & id_mask;
  assign merged      = state_cur.pending |
                       (WORD_BITS'(id_val) << state_cur.fill);
  assign total       = {1'b0, state_cur.fill} + (CNT_BITS + 1)'(width);
  assign rem         = total[CNT_BITS-1:0];
  assign carry_shift = width - CFG_BITS'(rem);
  assign carry_bits  = id_val >> carry_shift;

  always_comb begin
    state_nxt     = state_cur;
    word          = merged;
    ctl.emit      = 1'b0;
    ctl.word_last = 1'b0;
    ctl.done      = 1'b1;
    if (flush_phase) begin
      // Second word of a straddling chunk end: pending remainder, padded
      word              = state_cur.pending;
      ctl.emit          = 1'b1;
      ctl.word_last     = 1'b1;
      state_nxt.pending = '0;
      state_nxt.fill    = '0;
    end else if (total[CNT_BITS]) begin
      // Word filled: emit it, keep the spilled high bits of the id
      ctl.emit          = 1'b1;
      ctl.word_last     = id_last && (rem == '0);
      state_nxt.pending = (rem != '0) ? WORD_BITS'(carry_bits) : '0;
      state_nxt.fill    = rem;
      ctl.done          = !(id_last && (rem != '0));
    end else if (id_last) begin
      // Chunk end inside the word: flush it padded with zeros
      ctl.emit          = 1'b1;
      ctl.word_last     = 1'b1;
      state_nxt.pending = '0;
      state_nxt.fill    = '0;
    end else begin
      state_nxt.pending = merged;
      state_nxt.fill    = rem;
    end
  end

endmodule

>>> rtl/core/variable_width_id_packer_unit.sv
// A word reaches out_* through the input stage (s1) and then the output register.
// Throughput: one id per cycle unless the output stalls; a chunk-end id that spills
//   past a word boundary holds the input stage for an extra flush step, since the single
//   output register takes one word per cycle.
// Reset (rst_n low, synchronous): pipeline and output emptied, no bits pending,
//   bits_per_id back to 32.
module variable_width_id_packer_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration write: bits_per_id
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [vwip_pkg::CFG_BITS-1:0]       cfg_data,
  // input stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [vwip_pkg::ID_BITS-1:0]        in_tdata,   // [31:0] id_value
  input  logic                                in_tlast,   // chunk_end
  // output stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [vwip_pkg::WORD_BITS-1:0]      out_tdata,  // [63:0] packed_word
  output logic                                out_tlast   // word_last
);
  import vwip_pkg::*;

  logic [CFG_BITS-1:0]  bpi_r;
  logic [CFG_BITS-1:0]  width;

  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic [ID_BITS-1:0]   s1_id_r;
  logic                 s1_last_r;
  logic                 s1_flush_r;
  logic                 s1_flush_nxt;

  pack_state_t          state_r;
  pack_state_t          state_nxt;
  pack_ctl_t            ctl;
  logic [WORD_BITS-1:0] word;

  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [WORD_BITS-1:0] out_word_r;
  logic                 out_last_r;

  logic                 out_free;
  logic                 fire;
  logic                 in_xfer;

  // Configuration register, always ready
  assign cfg_ready = 1'b1;
  assign width     = eff_width(bpi_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bpi_r <= BPI_RESET;
    end else if (cfg_valid) begin
      bpi_r <= cfg_data;
    end
  end

  // Packing datapath
  vwip_pack u_pack (
    .state_cur   (state_r),
    .id_raw      (s1_id_r),
    .id_last     (s1_last_r),
    .flush_phase (s1_flush_r),
    .width       (width),
    .state_nxt   (state_nxt),
    .word        (word),
    .ctl         (ctl)
  );

  // Step control: a step that emits needs the output register free
  assign out_free  = !out_valid_r || out_tready;
  assign fire      = s1_valid_r && (!ctl.emit || out_free);
  assign in_tready = !s1_valid_r || (fire && ctl.done);
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    s1_flush_nxt = s1_flush_r;
    if (fire) begin
      s1_valid_nxt = !ctl.done;
      s1_flush_nxt = !ctl.done;
    end
    if (in_xfer) begin
      s1_valid_nxt = 1'b1;
      s1_flush_nxt = 1'b0;
    end
  end

  // Input stage and packing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_flush_r <= 1'b0;
      state_r    <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s1_flush_r <= s1_flush_nxt;
      if (fire) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_id_r   <= in_tdata;
      s1_last_r <= in_tlast;
    end
  end

  // Output register: load on an emitting step, drop after a transfer
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = fire && ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ctl.emit) begin
      out_word_r <= word;
      out_last_r <= ctl.word_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // Bits at and above the fill count stay zero
  a_pending_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.pending >> state_r.fill) == '0)
    else $error("pending bits above fill count");

  // The flush phase only exists for a held chunk-end item
  a_flush_held: assert property (@(posedge clk) disable iff (!rst_n)
    s1_flush_r |-> (s1_valid_r && s1_last_r))
    else $error("flush phase without chunk-end item");

  // A finished chunk-end item leaves nothing pending
  a_chunk_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctl.done && s1_last_r) |=> (state_r.fill == '0 && state_r.pending == '0))
    else $error("state not cleared after chunk end");

  // An emitting step always lands in the output register
  a_emit_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && ctl.emit) |=> out_valid_r)
    else $error("emitted word lost");
`endif

endmodule
